>>> src/brl_pkg.sv
package brl_pkg;

  // Default coordinate width and line queue depth
  localparam int unsigned COORD_BITS_DEF  = 6;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Walker status seen by the top level
  typedef struct packed {
    logic busy;     // a line is being walked
    logic err_neg;  // error accumulator sign (never set while walking)
  } brl_walk_status_t;

endpackage

>>> src/brl_front.sv
module brl_front #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic                  q_full,
  output logic                  q_push,
  output logic                  steep,
  output logic                  minor_down,
  output logic [COORD_BITS-1:0] major_start,
  output logic [COORD_BITS-1:0] major_end,
  output logic [COORD_BITS-1:0] minor_start,
  output logic [COORD_BITS-1:0] delta_major,
  output logic [COORD_BITS-1:0] delta_minor
);

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] maj0, maj1, min0, min1;
  logic                  swap;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    dx    = (in_start_x > in_end_x) ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    dy    = (in_start_y > in_end_y) ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    steep = dy > dx;
    if (steep) begin
      maj0 = in_start_y; min0 = in_start_x; maj1 = in_end_y; min1 = in_end_x;
    end else begin
      maj0 = in_start_x; min0 = in_start_y; maj1 = in_end_x; min1 = in_end_y;
    end
    // walk always runs toward the higher major coordinate
    swap        = maj0 > maj1;
    major_start = swap ? maj1 : maj0;
    major_end   = swap ? maj0 : maj1;
    minor_start = swap ? min1 : min0;
    delta_major = swap ? (maj0 - maj1) : (maj1 - maj0);
    delta_minor = steep ? dx : dy;
    minor_down  = swap ? !(min1 < min0) : !(min0 < min1);
  end

endmodule

>>> src/brl_queue.sv
module brl_queue #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = brl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/brl_walker.sv
module brl_walker #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  output logic                      q_pop,
  input  logic                      steep,
  input  logic                      minor_down,
  input  logic [COORD_BITS-1:0]     major_start,
  input  logic [COORD_BITS-1:0]     major_end,
  input  logic [COORD_BITS-1:0]     minor_start,
  input  logic [COORD_BITS-1:0]     delta_major,
  input  logic [COORD_BITS-1:0]     delta_minor,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_BITS-1:0]     out_point_x,
  output logic [COORD_BITS-1:0]     out_point_y,
  output logic                      out_last_point,
  output brl_pkg::brl_walk_status_t status
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                  state_r;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic                    last_r;
  logic [COORD_BITS-1:0]   maj_pos_r, maj_end_r, min_pos_r, dmaj_r, dmin_r;
  logic signed [COORD_BITS:0] err_r;
  logic                    steep_r, down_r;

  logic                    can_emit, at_end;
  logic signed [COORD_BITS:0] err_sub, err_nxt;
  logic [COORD_BITS-1:0]   min_nxt;

  assign can_emit = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_not_empty;
  assign at_end   = maj_pos_r == maj_end_r;

  always_comb begin
    err_sub = err_r - $signed({1'b0, dmin_r});
    if (err_sub[COORD_BITS]) begin
      err_nxt = err_sub + $signed({1'b0, dmaj_r});
      min_nxt = down_r ? (min_pos_r - 1'b1) : (min_pos_r + 1'b1);
    end else begin
      err_nxt = err_sub;
      min_nxt = min_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            maj_pos_r <= major_start;
            maj_end_r <= major_end;
            min_pos_r <= minor_start;
            dmaj_r    <= delta_major;
            dmin_r    <= delta_minor;
            err_r     <= $signed({2'b00, delta_major[COORD_BITS-1:1]});
            steep_r   <= steep;
            down_r    <= minor_down;
            state_r   <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (can_emit) begin
            out_valid_r <= 1'b1;
            px_r        <= steep_r ? min_pos_r : maj_pos_r;
            py_r        <= steep_r ? maj_pos_r : min_pos_r;
            last_r      <= at_end;
            err_r       <= err_nxt;
            min_pos_r   <= min_nxt;
            if (at_end) begin
              state_r <= ST_IDLE;
            end else begin
              maj_pos_r <= maj_pos_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_last_point = last_r;

  assign status.busy    = state_r == ST_WALK;
  assign status.err_neg = err_r[COORD_BITS];

endmodule

>>> src/bresenham_line_rasterizer.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------
// in_      | input     | in_valid/in_stall  | start_x, start_y, end_x, end_y
// out_     | output    | out_valid/out_stall| point_x, point_y, last_point
//
// In the walker a line is first loaded from the line queue, then walked at one
// point per cycle while out_stall does not hold the output (up to 64 points at the default width).
// The walker's single point/step loop sets that rate.
// The front classifies one line per cycle and stalls only when the queue is full.
// rst_n is synchronous, active low; it empties the queue and idles the walker.
// out_stall holds the output register and freezes the walk; in_stall follows queue full.
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS  = brl_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_last_point
);

  // Line descriptor: steep, minor_down, then five coordinate-wide fields
  localparam int unsigned DESC_W = 5 * COORD_BITS + 2;

  logic                  q_full, q_push, q_pop, q_not_empty;
  logic [DESC_W-1:0]     push_desc, pop_desc;

  // front-side descriptor
  logic                  f_steep, f_down;
  logic [COORD_BITS-1:0] f_maj0, f_maj1, f_min0, f_dmaj, f_dmin;

  // back-side descriptor
  logic                  b_steep, b_down;
  logic [COORD_BITS-1:0] b_maj0, b_maj1, b_min0, b_dmaj, b_dmin;

  brl_pkg::brl_walk_status_t walk_status;

  // Front: classify steep/direction, order endpoints, compute deltas
  brl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .q_full      (q_full),
    .q_push      (q_push),
    .steep       (f_steep),
    .minor_down  (f_down),
    .major_start (f_maj0),
    .major_end   (f_maj1),
    .minor_start (f_min0),
    .delta_major (f_dmaj),
    .delta_minor (f_dmin)
  );

  assign push_desc = {f_steep, f_down, f_maj0, f_maj1, f_min0, f_dmaj, f_dmin};

  // Short queue of classified lines between front and walker
  brl_queue #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_desc)
  );

  assign {b_steep, b_down, b_maj0, b_maj1, b_min0, b_dmaj, b_dmin} = pop_desc;

  // Back: error-accumulator walk, one point per cycle into the output register while out_stall does not hold it
  brl_walker #(.COORD_BITS(COORD_BITS)) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_pop          (q_pop),
    .steep          (b_steep),
    .minor_down     (b_down),
    .major_start    (b_maj0),
    .major_end      (b_maj1),
    .minor_start    (b_min0),
    .delta_major    (b_dmaj),
    .delta_minor    (b_dmin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .status         (walk_status)
  );

  // A non-final point leaving means the walker still has the rest of the line,
  // so the next point is ready right behind it.
  a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_point) |=> out_valid)
    else $error("gap inside a line");

  // Error accumulator stays non-negative between steps of a walk
  a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    walk_status.busy |-> !walk_status.err_neg)
    else $error("error accumulator negative during walk");

  // A stalled output keeps the walk in progress
  a_stall_holds_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && walk_status.busy) |=> walk_status.busy)
    else $error("walker advanced under output stall");

endmodule
